// ----- rtl/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window maximum block
// Widths, register map, controller states and the command/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int POS_W          = 32;
  localparam int WSIZE_W        = 7;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 2;
  localparam int WINDOW_MAX_DEF = 64;

  localparam logic [APB_ADDR_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [WSIZE_W-1:0]    WSIZE_RESET     = 7'd1;

  typedef enum logic {
    S_IDLE,
    S_CHECK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic drop_head;
    logic drop_tail;
    logic push;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic front_stale;
    logic back_le;
    logic emit;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/swm_if.sv -----
// ----------------------------------------------------------------------------
// swm_if: valid/ready channels of the sliding window maximum block
// swm_in_if carries one sample transaction, swm_out_if one result.
// ----------------------------------------------------------------------------
interface swm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

// ----- rtl/swm_ctrl.sv -----
// ----------------------------------------------------------------------------
// swm_ctrl: sequencer of the sliding window maximum block
// Takes one transaction, then pops stale front entries and dominated back
// entries one per cycle before pushing the new sample.
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  swm_pkg::dp_status_t   status,
  output swm_pkg::dp_cmd_t      cmd
);
  import swm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.front_stale) begin
          cmd.drop_head = 1'b1;
        end else if (status.back_le) begin
          cmd.drop_tail = 1'b1;
        end else if (!(status.emit && status.out_busy)) begin
          // hold while a result is due and the output register is still full
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/swm_dpath.sv -----
// ----------------------------------------------------------------------------
// swm_dpath: deque storage and arithmetic of the sliding window maximum
// Circular deque memory with head and tail read ports, run counters and
// the output register.
// ----------------------------------------------------------------------------
module swm_dpath #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swm_pkg::dp_cmd_t                    cmd,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_restart,
  input  logic [swm_pkg::WSIZE_W-1:0]         window_size,
  output swm_pkg::dp_status_t                 status,
  output logic                                out_valid,
  output logic signed [swm_pkg::SAMPLE_W-1:0] out_window_max,
  input  logic                                out_ready
);
  import swm_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_MAX - 1);

  // deque storage
  logic signed [SAMPLE_W-1:0] val_mem [WINDOW_MAX];
  logic [POS_W-1:0]           pos_mem [WINDOW_MAX];

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [KW-1:0]              k_r;
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [KW-1:0]              occ_r, occ_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [KW-1:0]              warm_r, warm_nxt;
  logic signed [SAMPLE_W-1:0] head_val_r;
  logic [POS_W-1:0]           head_pos_r;
  logic signed [SAMPLE_W-1:0] back_val_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r;

  logic [KW-1:0]              k_eff;
  logic [KW-1:0]              warm_new;
  logic [AW-1:0]              back_rd_addr;
  logic signed [SAMPLE_W-1:0] front_val;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  // clamp the programmed window length to 1..WINDOW_MAX
  always_comb begin
    if (window_size == '0) begin
      k_eff = KW'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      k_eff = KW'(WINDOW_MAX);
    end else begin
      k_eff = KW'(window_size);
    end
  end

  assign warm_new  = (warm_r < k_r) ? warm_r + 1'b1 : k_r;
  assign front_val = (occ_r == '0) ? sample_r : head_val_r;

  always_comb begin
    status.front_stale = (occ_r != '0) && ((pos_r - head_pos_r) >= POS_W'(k_r));
    status.back_le     = (occ_r != '0) && (back_val_r <= sample_r);
    status.emit        = (warm_new == k_r);
    status.out_busy    = out_valid_r && !out_ready;
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    pos_nxt  = pos_r;
    warm_nxt = warm_r;
    if (cmd.accept && in_restart) begin
      head_nxt = '0;
      tail_nxt = '0;
      occ_nxt  = '0;
      pos_nxt  = '0;
      warm_nxt = '0;
    end
    if (cmd.drop_head) begin
      head_nxt = ptr_next(head_r);
      occ_nxt  = occ_r - 1'b1;
    end
    if (cmd.drop_tail) begin
      tail_nxt = ptr_prev(tail_r);
      occ_nxt  = occ_r - 1'b1;
    end
    if (cmd.push) begin
      tail_nxt = ptr_next(tail_r);
      occ_nxt  = occ_r + 1'b1;
      pos_nxt  = pos_r + 1'b1;
      warm_nxt = warm_new;
    end
  end

  assign back_rd_addr = ptr_prev(tail_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      pos_r       <= '0;
      warm_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
      pos_r  <= pos_nxt;
      warm_r <= warm_nxt;
      if (cmd.push && status.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      k_r      <= k_eff;
    end
    if (cmd.push && status.emit) begin
      out_data_r <= front_val;
    end
  end

  // memory: one write port at the tail, read ports at head and tail - 1
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      val_mem[tail_r] <= sample_r;
      pos_mem[tail_r] <= pos_r;
    end
    head_val_r <= val_mem[head_nxt];
    head_pos_r <= pos_mem[head_nxt];
    back_val_r <= val_mem[back_rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_data_r;

endmodule

// ----- rtl/sliding_window_maximum.sv -----
// ----------------------------------------------------------------------------
// sliding_window_maximum: streaming maximum over the last window_size samples
// Top level: APB register, sequencer and deque datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one signed 32-bit sample per transaction plus a restart
//   flag that empties the window before the sample is taken. out_ch carries
//   window_max, the largest of the last window_size samples; a transaction
//   produces a result only once window_size samples have arrived since reset
//   or restart. The user must write window_size at APB address 0 only while
//   idle (the block does not enforce it); it is clamped to 1..WINDOW_MAX.
// Timing:
//   One sample is in flight at a time. After taking it, the sequencer pops
//   deque entries one at a time (stale front or dominated back entries),
//   each pop being one access of the deque memory's read ports, and then
//   pushes the sample. Every sample is pushed once and popped at most once.
//   A result appears in the output register in the cycle after push.
// Reset and stall:
//   rst_n (synchronous) empties the deque, clears the counters and sets
//   window_size to 1; deque memory needs no clearing pass. The output
//   register lets the next sample enter while a result waits; if a second
//   result is due while the receiver still stalls, hold before the push.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  swm_in_if.sink                            in_ch,
  swm_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [swm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [swm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import swm_pkg::*;

  logic [WSIZE_W-1:0] window_size_r;
  logic               cfg_wr;
  dp_cmd_t            cmd;
  dp_status_t         status;

  // APB register: zero wait states, writes outside the map are dropped
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WSIZE_RESET;
    end else if (cfg_wr) begin
      window_size_r <= pwdata[WSIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr)
      REG_WINDOW_SIZE: prdata = APB_DATA_W'(window_size_r);
      default:         prdata = '0;
    endcase
  end

  // sequencer: accept, pop front/back one per cycle, push
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // deque memory, counters and output register
  swm_dpath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_sample      (in_ch.sample),
    .in_restart     (in_ch.restart),
    .window_size    (window_size_r),
    .status         (status),
    .out_valid      (out_ch.valid),
    .out_window_max (out_ch.window_max),
    .out_ready      (out_ch.ready)
  );

endmodule

// ----- rtl/swm_chk.sv -----
// ----------------------------------------------------------------------------
// swm_chk: port-level checks for the sliding window maximum block
// Bound to the top level; watches the channels and the APB port only.
// ----------------------------------------------------------------------------
module swm_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [swm_pkg::SAMPLE_W-1:0]      out_window_max,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [swm_pkg::APB_ADDR_W-1:0]    paddr,
  input logic [swm_pkg::APB_DATA_W-1:0]    prdata
);
  import swm_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_max))
    else $error("result changed while stalled");

  // one sample at a time: after a transaction the input side closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in flight");

  // a new result appears as the sequencer finishes and reopens the input
  a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while a sample is still being processed");

  // window_size readback uses only its low bits
  a_cfg_read: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && !pwrite && (paddr == REG_WINDOW_SIZE)
      |-> prdata[APB_DATA_W-1:WSIZE_W] == '0)
    else $error("window_size readback has stray upper bits");

endmodule

bind sliding_window_maximum swm_chk u_swm_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_window_max (out_ch.window_max),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .prdata         (prdata)
);
